FILE: rtl/core/bblru_pkg.sv
// Package for the byte-budget LRU table: request and status codes, widths,
// and the size record that the sequencer passes to the arithmetic unit.
// No dependencies.
package bblru_pkg;

  localparam int KEY_W    = 64;
  localparam int CAP_W    = 12;
  localparam int BYTES_W  = 32;
  localparam int CNT_W    = 32;
  localparam int EVN_W    = 9;
  localparam int MIB_SHIFT = 20;

  typedef enum logic [1:0] {
    REQ_GET   = 2'd0,
    REQ_PUT   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_TRIM  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_NOBUF   = 2'd2,
    ST_TOOBIG  = 2'd3
  } status_t;

  // one compare of held bytes plus needed bytes against the budget
  typedef struct packed {
    logic [BYTES_W-1:0] used;
    logic [BYTES_W:0]   need;
    logic [CAP_W-1:0]   cap_mb;
  } fit_req_t;

endpackage

FILE: rtl/core/byte_budget_lru_cache.sv
// byte_budget_lru_cache: 64-bit keyed LRU table with a byte budget and up
// to ENTRIES entries. Clear and a put without a buffer end after the size
// step, a trim with nothing to evict after one budget test, and a put that
// is too large at the first step of the key search. A get miss takes a key
// search; a get hit takes a key search, then a touch pass. An accepted put
// takes a key search, a budget test, a full-table scan, an age pass and an
// insert; replacing a key adds a removal pass. Each eviction for bytes, on
// a put or a trim, adds one scan of the table for the least recent entry,
// one removal pass and a new budget test, and the full-table eviction adds
// a removal pass. All scans step one entry per cycle through one key
// comparator and one rank comparator; the budget test is one shared
// add-and-compare. Size is samples*channels*4, one 24x5 multiply
// registered before use. Results leave through an output register; the
// input is not ready while a result waits there, and is ready again in the
// cycle after the result transfer.
module byte_budget_lru_cache
  import bblru_pkg::*;
#(
  parameter int ENTRIES     = 16,
  parameter int HANDLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // requests
  input  logic        s_tvalid,
  output logic        s_tready,
  // {key[63:0], has_buffer, num_samples[23:0], num_channels[4:0],
  //  buffer_handle[31:0]} from bit 0 up, zero padded to 128 bits
  input  logic [127:0] s_tdata,
  input  logic [1:0]   s_tuser,   // req_type
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  // {status[1:0], handle_out[31:0], evicted_now[8:0], used_bytes_out[31:0],
  //  hit_total, miss_total, eviction_total} from bit 0 up, padded to 176 bits
  output logic [175:0] m_tdata
);
  localparam int IW = $clog2(ENTRIES);
  localparam int RW = $clog2(ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_SIZE, S_FIND, S_FOUND, S_BUDGET, S_LRU, S_REMOVE, S_FULL,
    S_AGE, S_INSERT, S_DONE
  } state_t;

  state_t state;

  logic [CAP_W-1:0] cap_mb;

  // table
  logic [ENTRIES-1:0]   valid;
  logic [KEY_W-1:0]     ekey   [ENTRIES];
  logic [30:0]          ebytes [ENTRIES];
  logic [HANDLE_BITS-1:0] ehandle [ENTRIES];
  logic [RW-1:0]        erank  [ENTRIES];

  logic [BYTES_W-1:0] used;
  logic [CNT_W-1:0]   hits, misses, evicts;

  // request latch
  req_t              req;
  logic [KEY_W-1:0]  rkey;
  logic              rbuf;
  logic [23:0]       rsamp;
  logic [4:0]        rchan;
  logic [HANDLE_BITS-1:0] rhandle;
  logic [BYTES_W:0]  rbytes;

  // scan state
  logic [IW:0]    ptr;
  logic           found;
  logic [IW-1:0]  sel;
  logic [RW-1:0]  sel_rank;
  logic [IW-1:0]  free_idx;
  logic           have_free;
  logic [EVN_W-1:0] evn;
  logic           sweep_remove; // removal pass after find (not an eviction)
  logic           full_pass;

  logic [1:0]            r_status;
  logic [HANDLE_BITS-1:0] r_hout;

  logic [IW-1:0] pi;
  assign pi = ptr[IW-1:0];

  fit_req_t fr;
  logic     over;

  assign fr.used   = used;
  assign fr.need   = (req == REQ_PUT) ? rbytes : '0;
  assign fr.cap_mb = cap_mb;

  bblru_fit u_fit (.req(fr), .over(over));

  assign pready   = 1'b1;
  assign prdata   = {20'd0, cap_mb};
  assign s_tready = (state == S_IDLE) && !m_tvalid;

  logic [31:0] hout32;
  assign hout32 = 32'(r_hout);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cap_mb   <= CAP_W'(256);
      valid    <= '0;
      used     <= '0;
      hits     <= '0;
      misses   <= '0;
      evicts   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (psel && penable && pwrite && !paddr) cap_mb <= pwdata[CAP_W-1:0];
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            req     <= req_t'(s_tuser);
            rkey    <= s_tdata[63:0];
            rbuf    <= s_tdata[64];
            rsamp   <= s_tdata[88:65];
            rchan   <= s_tdata[93:89];
            rhandle <= HANDLE_BITS'(s_tdata[125:94] & {32{1'b1}});
            ptr     <= '0;
            found   <= 1'b0;
            evn     <= '0;
            r_status <= ST_OK;
            r_hout  <= '0;
            sweep_remove <= 1'b0;
            full_pass <= 1'b0;
            have_free <= 1'b0;
            state   <= S_SIZE;
          end
        end
        S_SIZE: begin
          rbytes <= {(BYTES_W+1-31)'(0), 29'(rsamp) * 29'(rchan), 2'b00};
          unique case (req)
            REQ_GET:   state <= S_FIND;
            REQ_PUT:   state <= rbuf ? S_FIND : S_DONE;
            REQ_CLEAR: begin valid <= '0; used <= '0; state <= S_DONE; end
            REQ_TRIM:  state <= S_BUDGET;
          endcase
          if (req == REQ_PUT && !rbuf) r_status <= ST_NOBUF;
        end
        // one key compare per cycle
        S_FIND: begin
          if (req == REQ_PUT && rbytes > {1'b0, cap_mb, 20'd0}) begin
            r_status <= ST_TOOBIG;
            state <= S_DONE;
          end else begin
            if (!found && valid[pi] && ekey[pi] == rkey) begin
              found <= 1'b1; sel <= pi; sel_rank <= erank[pi];
            end
            if (ptr == (IW+1)'(ENTRIES-1)) state <= S_FOUND;
            else ptr <= ptr + 1'b1;
          end
        end
        S_FOUND: begin
          ptr <= '0;
          if (req == REQ_GET) begin
            if (found) begin
              hits <= hits + 1'b1; r_hout <= ehandle[sel];
              state <= S_AGE;    // touch pass
            end else begin
              misses <= misses + 1'b1; r_status <= ST_MISS; state <= S_DONE;
            end
          end else if (found) begin
            sweep_remove <= 1'b1; state <= S_REMOVE;
          end else state <= S_BUDGET;
        end
        S_BUDGET: begin
          ptr <= '0; found <= 1'b0;
          if (over && valid != '0) state <= S_LRU;
          else if (req == REQ_TRIM) state <= S_DONE;
          else state <= S_FULL;
        end
        // one rank compare per cycle
        S_LRU: begin
          if (valid[pi]) begin
            if (!found || erank[pi] > sel_rank) begin
              found <= 1'b1; sel <= pi; sel_rank <= erank[pi];
            end
          end
          if (ptr == (IW+1)'(ENTRIES-1)) begin
            ptr <= '0; state <= S_REMOVE;
          end else ptr <= ptr + 1'b1;
        end
        // one rank decrement per cycle, then free the slot
        S_REMOVE: begin
          if (valid[pi] && erank[pi] > sel_rank) erank[pi] <= erank[pi] - 1'b1;
          if (ptr == (IW+1)'(ENTRIES-1)) begin
            valid[sel] <= 1'b0;
            used <= used - 32'(ebytes[sel]);
            ptr <= '0;
            if (sweep_remove) begin
              sweep_remove <= 1'b0;
              state <= S_BUDGET;
            end else begin
              evicts <= evicts + 1'b1;
              evn <= evn + 1'b1;
              state <= full_pass ? S_AGE : S_BUDGET;
            end
          end else ptr <= ptr + 1'b1;
        end
        // full-table check: one LRU scan, evict if every slot is valid
        S_FULL: begin
          if (valid[pi]) begin
            if (!found || erank[pi] > sel_rank) begin
              found <= 1'b1; sel <= pi; sel_rank <= erank[pi];
            end
          end
          if (ptr == (IW+1)'(ENTRIES-1)) begin
            ptr <= '0;
            if (&valid) begin full_pass <= 1'b1; state <= S_REMOVE; end
            else state <= S_AGE;
          end else ptr <= ptr + 1'b1;
        end
        // age pass: touch for get, increment all for put; find free slot
        S_AGE: begin
          if (req == REQ_GET) begin
            if (valid[pi] && erank[pi] < sel_rank) erank[pi] <= erank[pi] + 1'b1;
          end else if (valid[pi]) erank[pi] <= erank[pi] + 1'b1;
          else if (!have_free) begin
            free_idx <= pi; have_free <= 1'b1;
          end
          if (ptr == (IW+1)'(ENTRIES-1)) state <= S_INSERT;
          else ptr <= ptr + 1'b1;
        end
        S_INSERT: begin
          if (req == REQ_GET) erank[sel] <= '0;
          else begin
            valid[free_idx]   <= 1'b1;
            ekey[free_idx]    <= rkey;
            ebytes[free_idx]  <= rbytes[30:0];
            ehandle[free_idx] <= rhandle;
            erank[free_idx]   <= '0;
            used <= used + rbytes[BYTES_W-1:0];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          m_tvalid <= 1'b1;
          m_tdata  <= {5'd0, evicts, misses, hits, used,
                       (req == REQ_GET || req == REQ_CLEAR) ? 9'd0 : evn,
                       hout32, r_status};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/core/bblru_fit.sv
// Shared compare unit: checks whether used+need exceeds the byte budget.
// Depends on bblru_pkg.
module bblru_fit
  import bblru_pkg::*;
(
  input  fit_req_t req,
  output logic     over
);
  logic [BYTES_W+1:0] sum;
  logic [BYTES_W+1:0] cap;

  // 34-bit add and compare
  assign sum  = {2'b00, req.used} + {1'b0, req.need};
  assign cap  = {2'b00, req.cap_mb, {MIB_SHIFT{1'b0}}};
  assign over = sum > cap;
endmodule

FILE: rtl/core/bblru_checker.sv
// Port-level checks for byte_budget_lru_cache, bound to the top level.
// Depends on bblru_pkg.
module bblru_checker
  import bblru_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [175:0] m_tdata
);
  // not ready while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("ready with result pending");
  // accepted request is not answered next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !m_tvalid) else $error("result too early");
  // handle is zero unless status ok
  a_hout: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != ST_OK) |-> m_tdata[33:2] == 32'd0)
    else $error("handle on non-hit");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result changed");
endmodule

bind byte_budget_lru_cache bblru_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
